// ===== src/idc_pkg.sv =====
// ----------------------------------------------------------------------------
// Impact detector package
// Shared types, codes and constants of the impact detector and direction
// classifier.
// ----------------------------------------------------------------------------
package idc_pkg;

  // Detection timing.
  localparam logic [2:0]  WINDOW_SAMPLES  = 3'd6;
  localparam logic [1:0]  CALM_NEEDED     = 2'd2;
  localparam logic [31:0] COOL_TIMEOUT_MS = 32'd250;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OFFSET_X      = 3'd0,
    REG_OFFSET_Y      = 3'd1,
    REG_OFFSET_Z      = 3'd2,
    REG_STYLE         = 3'd3,
    REG_SECOND_PLAYER = 3'd4,
    REG_STRIKE_LEVEL  = 3'd5,
    REG_CALM_LEVEL    = 3'd6,
    REG_AXIS_ZONE     = 3'd7
  } reg_idx_t;

  // Register reset values.
  localparam logic [17:0] STRIKE_LEVEL_RST = 18'd6000;
  localparam logic [17:0] CALM_LEVEL_RST   = 18'd1500;
  localparam logic [16:0] AXIS_ZONE_RST    = 17'd4000;

  typedef enum logic [1:0] {
    PH_READY  = 2'd0,
    PH_DETECT = 2'd1,
    PH_COOL   = 2'd2
  } phase_t;

  localparam logic [1:0] ZONE_MIDDLE = 2'd0;
  localparam logic [1:0] ZONE_LEFT   = 2'd1;
  localparam logic [1:0] ZONE_RIGHT  = 2'd2;

  localparam logic [1:0] LED_RED    = 2'd0;
  localparam logic [1:0] LED_YELLOW = 2'd1;
  localparam logic [1:0] LED_PURPLE = 2'd2;

  localparam logic [1:0] STYLE_ROCK  = 2'd0;
  localparam logic [1:0] STYLE_METAL = 2'd1;

  localparam logic [3:0] BASE_ROCK     = 4'd1;
  localparam logic [3:0] BASE_METAL    = 4'd4;
  localparam logic [3:0] BASE_METAL_P2 = 4'd5;
  localparam logic [3:0] BASE_ALT      = 4'd8;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
    logic [1:0]         style;
    logic               second_player;
    logic [17:0]        strike_level;
    logic [17:0]        calm_level;
    logic [16:0]        axis_zone;
  } cfg_t;

  // One sample after offset removal, as held in the input stage.
  typedef struct packed {
    logic               rearm;
    logic signed [16:0] dy;
    logic [17:0]        mag;
    logic [31:0]        time_ms;
  } sample_t;

endpackage

// ===== src/idc_if.sv =====
// ----------------------------------------------------------------------------
// Impact detector channels
// Valid/ready channels for accelerometer samples and hit results.
// ----------------------------------------------------------------------------
interface idc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [31:0]        time_ms;
  logic               rearm;

  modport source (output valid, accel_x, accel_y, accel_z, time_ms, rearm, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, rearm, output ready);
endinterface

interface idc_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] zone;
  logic [3:0] track;
  logic [1:0] led_color;
  logic [1:0] phase_now;

  modport source (output valid, hit, zone, track, led_color, phase_now, input ready);
  modport sink   (input valid, hit, zone, track, led_color, phase_now, output ready);
endinterface

// ===== src/idc_cfg.sv =====
// ----------------------------------------------------------------------------
// Impact detector configuration registers
// Holds the calibration offsets, style and player selection and thresholds.
// ----------------------------------------------------------------------------
module idc_cfg
  import idc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x      <= '0;
      cfg_r.offset_y      <= '0;
      cfg_r.offset_z      <= '0;
      cfg_r.style         <= STYLE_ROCK;
      cfg_r.second_player <= 1'b0;
      cfg_r.strike_level  <= STRIKE_LEVEL_RST;
      cfg_r.calm_level    <= CALM_LEVEL_RST;
      cfg_r.axis_zone     <= AXIS_ZONE_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_OFFSET_X:      cfg_r.offset_x      <= $signed(cfg_wdata[15:0]);
        REG_OFFSET_Y:      cfg_r.offset_y      <= $signed(cfg_wdata[15:0]);
        REG_OFFSET_Z:      cfg_r.offset_z      <= $signed(cfg_wdata[15:0]);
        REG_STYLE:         cfg_r.style         <= cfg_wdata[1:0];
        REG_SECOND_PLAYER: cfg_r.second_player <= cfg_wdata[0];
        REG_STRIKE_LEVEL:  cfg_r.strike_level  <= cfg_wdata[17:0];
        REG_CALM_LEVEL:    cfg_r.calm_level    <= cfg_wdata[17:0];
        REG_AXIS_ZONE:     cfg_r.axis_zone     <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/idc_front.sv =====
// ----------------------------------------------------------------------------
// Impact detector input stage
// Removes the offsets, forms the L1 magnitude and registers the sample.
// ----------------------------------------------------------------------------
module idc_front
  import idc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  idc_in_if.sink     in_chan,
  input  cfg_t       cfg,
  input  logic       advance,
  output logic       smp_valid,
  output sample_t    smp
);

  logic               smp_valid_r;
  sample_t            smp_r;
  logic signed [16:0] dx, dy, dz;
  logic [15:0]        ax, ay, az;
  logic               accept;

  assign dx = $signed({in_chan.accel_x[15], in_chan.accel_x})
            - $signed({cfg.offset_x[15], cfg.offset_x});
  assign dy = $signed({in_chan.accel_y[15], in_chan.accel_y})
            - $signed({cfg.offset_y[15], cfg.offset_y});
  assign dz = $signed({in_chan.accel_z[15], in_chan.accel_z})
            - $signed({cfg.offset_z[15], cfg.offset_z});

  // Magnitudes never exceed 65535, so the low 16 bits of the negation suffice.
  assign ax = dx[16] ? 16'(-dx) : dx[15:0];
  assign ay = dy[16] ? 16'(-dy) : dy[15:0];
  assign az = dz[16] ? 16'(-dz) : dz[15:0];

  // The stage takes a new sample when empty or when its sample moves on.
  assign in_chan.ready = !smp_valid_r || advance;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      smp_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r.rearm   <= in_chan.rearm;
      smp_r.dy      <= dy;
      smp_r.mag     <= {2'b00, ax} + {2'b00, ay} + {2'b00, az};
      smp_r.time_ms <= in_chan.time_ms;
    end
  end

  assign smp_valid = smp_valid_r;
  assign smp       = smp_r;

endmodule

// ===== src/idc_core.sv =====
// ----------------------------------------------------------------------------
// Impact detector phase machine and classifier
// Updates the ready/detecting/cooling state and registers one result per
// sample.
// ----------------------------------------------------------------------------
module idc_core
  import idc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     smp_valid,
  input  sample_t  smp,
  output logic     advance,
  idc_out_if.source out_chan
);

  phase_t             phase_r, phase_nxt;
  logic [2:0]         wcount_r, wcount_nxt;
  logic [15:0]        peak_hi_r, peak_hi_nxt;
  logic signed [16:0] peak_lo_r, peak_lo_nxt;
  logic [1:0]         calm_r, calm_nxt;
  logic [31:0]        cstart_r, cstart_nxt;

  logic       out_valid_r;
  logic       hit_r, hit_nxt;
  logic [1:0] zone_r, zone_nxt;
  logic [3:0] track_r, track_nxt;
  logic [1:0] led_r, led_nxt;

  logic        alt;
  logic [3:0]  base;
  logic [15:0] neg;
  logic [31:0] elapsed;

  assign advance = smp_valid && (!out_valid_r || out_chan.ready);

  assign alt  = (cfg.style != STYLE_ROCK) && (cfg.style != STYLE_METAL);
  assign base = (cfg.style == STYLE_ROCK) ? BASE_ROCK :
                (!alt ? (cfg.second_player ? BASE_METAL_P2 : BASE_METAL) : BASE_ALT);
  assign elapsed = smp.time_ms - cstart_r;

  // Peak tracking feeds the classifier with the peaks after this sample.
  always_comb begin
    peak_hi_nxt = peak_hi_r;
    peak_lo_nxt = peak_lo_r;
    if (smp.rearm) begin
      peak_hi_nxt = '0;
      peak_lo_nxt = '0;
    end else if (phase_r == PH_READY) begin
      if (smp.mag > cfg.strike_level) begin
        peak_hi_nxt = (!smp.dy[16]) ? smp.dy[15:0] : '0;
        peak_lo_nxt = smp.dy[16] ? smp.dy : '0;
      end
    end else if (phase_r == PH_DETECT) begin
      if (smp.dy > $signed({1'b0, peak_hi_r})) peak_hi_nxt = smp.dy[15:0];
      if (smp.dy < peak_lo_r)                  peak_lo_nxt = smp.dy;
    end
  end

  assign neg = 16'(-peak_lo_nxt);

  always_comb begin
    phase_nxt  = phase_r;
    wcount_nxt = wcount_r;
    calm_nxt   = calm_r;
    cstart_nxt = cstart_r;
    hit_nxt    = 1'b0;
    zone_nxt   = ZONE_MIDDLE;
    track_nxt  = '0;
    led_nxt    = LED_RED;
    if (smp.rearm) begin
      phase_nxt  = PH_READY;
      wcount_nxt = '0;
      calm_nxt   = '0;
    end else begin
      case (phase_r)
        PH_READY: begin
          if (smp.mag > cfg.strike_level) begin
            wcount_nxt = 3'd1;
            phase_nxt  = PH_DETECT;
          end
        end
        PH_DETECT: begin
          wcount_nxt = wcount_r + 3'd1;
          if (wcount_nxt >= WINDOW_SAMPLES) begin
            hit_nxt    = 1'b1;
            cstart_nxt = smp.time_ms;
            calm_nxt   = '0;
            phase_nxt  = PH_COOL;
            if (peak_hi_nxt > neg && {1'b0, peak_hi_nxt} > cfg.axis_zone) begin
              zone_nxt  = ZONE_RIGHT;
              track_nxt = alt ? base + 4'd1 : base + 4'd2;
              led_nxt   = alt ? LED_RED : LED_PURPLE;
            end else if (neg > peak_hi_nxt && {1'b0, neg} > cfg.axis_zone) begin
              zone_nxt  = ZONE_LEFT;
              track_nxt = alt ? base + 4'd2 : base + 4'd1;
              led_nxt   = alt ? LED_PURPLE : LED_RED;
            end else begin
              zone_nxt  = ZONE_MIDDLE;
              track_nxt = base;
              led_nxt   = LED_YELLOW;
            end
          end
        end
        default: begin
          if (smp.mag < cfg.calm_level) begin
            calm_nxt = calm_r + 2'd1;
            if (calm_nxt >= CALM_NEEDED) begin
              phase_nxt = PH_READY;
              calm_nxt  = '0;
            end
          end else if (elapsed > COOL_TIMEOUT_MS) begin
            phase_nxt = PH_READY;
            calm_nxt  = '0;
          end else begin
            calm_nxt = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_READY;
      wcount_r    <= '0;
      peak_hi_r   <= '0;
      peak_lo_r   <= '0;
      calm_r      <= '0;
      cstart_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r   <= phase_nxt;
        wcount_r  <= wcount_nxt;
        peak_hi_r <= peak_hi_nxt;
        peak_lo_r <= peak_lo_nxt;
        calm_r    <= calm_nxt;
        cstart_r  <= cstart_nxt;
      end
      if (!out_valid_r || out_chan.ready) begin
        out_valid_r <= smp_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit_r   <= hit_nxt;
      zone_r  <= zone_nxt;
      track_r <= track_nxt;
      led_r   <= led_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.hit       = hit_r;
  assign out_chan.zone      = zone_r;
  assign out_chan.track     = track_r;
  assign out_chan.led_color = led_r;
  assign out_chan.phase_now = phase_r;

endmodule

// ===== src/impact_detector_direction_classifier_top.sv =====
// ----------------------------------------------------------------------------
// Impact detector and direction classifier, top level
// Detects stick hits from accelerometer samples and classifies their direction.
// ----------------------------------------------------------------------------
// A result request is presented once its sample has passed the input stage
// register and then the result register, and a result stall can hold it there.
// Throughput: one sample per cycle while the result side takes every result;
// each stage register advances whenever the next stage is free or being drained.
// Reset (rst_n low, synchronous) empties both stages, puts the phase machine
// in ready with counters and peaks cleared, and loads the register defaults.
// ----------------------------------------------------------------------------
module impact_detector_direction_classifier_top
  import idc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  idc_in_if.sink                 in_chan,
  idc_out_if.source              out_chan,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Current register values, shared by both stages. Configuration must only be
  // rewritten while no request is in flight; the user, not the block, ensures it.
  cfg_t    cfg;

  // Input stage: offset-corrected Y deviation and L1 magnitude of a sample.
  logic    smp_valid;
  sample_t smp;

  // High when the held sample moves into the result register this cycle.
  logic    advance;

  idc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The offset subtraction and the magnitude sum are done before the input
  // register, so the phase machine sees only compares and small updates.
  idc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg),
    .advance   (advance),
    .smp_valid (smp_valid),
    .smp       (smp)
  );

  // The phase machine updates its state and loads the result register in the
  // same cycle, so the following sample already sees the new phase.
  idc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .smp_valid (smp_valid),
    .smp       (smp),
    .advance   (advance),
    .out_chan  (out_chan)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Impact detector and direction classifier testbench
// Drives timestamped accelerometer samples through the valid/ready channel,
// predicts every result with its own model of the phase machine, peak tracker
// and classifier, and compares the results field by field.
// ----------------------------------------------------------------------------
module testbench;
  import idc_pkg::*;

  // The run is stopped here if the block hangs.
  localparam int CYCLE_LIMIT = 200000;

  // One input request as seen on the sample channel.
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [31:0]        t;
    logic               rearm;
  } accel_sample_t;

  // One result request as expected on the result channel.
  typedef struct packed {
    logic       hit;
    logic [1:0] zone;
    logic [3:0] track;
    logic [1:0] led;
    phase_t     phase;
  } hit_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  idc_in_if  in_if ();
  idc_out_if out_if ();

  impact_detector_direction_classifier_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The testbench's copy of the configuration registers, at reset values.
  logic signed [15:0] cf_offset_x = '0;
  logic signed [15:0] cf_offset_y = '0;
  logic signed [15:0] cf_offset_z = '0;
  logic [1:0]         cf_style    = STYLE_ROCK;
  logic               cf_second   = 1'b0;
  logic [17:0]        cf_hit_thr  = STRIKE_LEVEL_RST;
  logic [17:0]        cf_rest_thr = CALM_LEVEL_RST;
  logic [16:0]        cf_axis     = AXIS_ZONE_RST;

  // The testbench's copy of the detector state, at reset values.
  phase_t             st_phase      = PH_READY;
  logic [2:0]         st_window     = '0;
  logic [15:0]        st_peak_hi    = '0;
  logic signed [16:0] st_peak_lo    = '0;
  logic [1:0]         st_calm       = '0;
  logic [31:0]        st_cool_start = '0;

  hit_result_t pending_results[$];

  int errors        = 0;
  int results_seen  = 0;
  int samples_sent  = 0;
  int rearms_sent   = 0;
  int hits_by_zone[3] = '{0, 0, 0};
  int cycle_count   = 0;
  int src_gap_pct;
  int sink_gap_pct;
  logic [31:0] stamp_ms = '0;

  function automatic logic [16:0] abs17(logic signed [16:0] v);
    return v[16] ? -v : v;
  endfunction

  // Direction, track and LED color of a finished detection window.
  function automatic hit_result_t classify_strike();
    logic        alt;
    logic [3:0]  base;
    logic [16:0] neg;
    logic [16:0] pos;
    hit_result_t r;
    alt = cf_style[1];
    if (cf_style == STYLE_ROCK) begin
      base = BASE_ROCK;
    end else if (cf_style == STYLE_METAL) begin
      base = cf_second ? BASE_METAL_P2 : BASE_METAL;
    end else begin
      base = BASE_ALT;
    end
    neg = abs17(st_peak_lo);
    pos = {1'b0, st_peak_hi};
    r = '0;
    r.hit = 1'b1;
    if (pos > neg && pos > cf_axis) begin
      r.zone  = ZONE_RIGHT;
      r.track = alt ? base + 4'd1 : base + 4'd2;
    end else if (neg > pos && neg > cf_axis) begin
      r.zone  = ZONE_LEFT;
      r.track = alt ? base + 4'd2 : base + 4'd1;
    end else begin
      r.zone  = ZONE_MIDDLE;
      r.track = base;
    end
    if (r.track == base + 4'd1) begin
      r.led = LED_RED;
    end else if (r.track == base) begin
      r.led = LED_YELLOW;
    end else begin
      r.led = LED_PURPLE;
    end
    return r;
  endfunction

  // Advances the detector state by one sample and returns its result.
  function automatic hit_result_t predict_hit_result(accel_sample_t s);
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] dz;
    logic [17:0]        mag;
    hit_result_t        r;
    r = '0;
    if (s.rearm) begin
      // A rearm request discards the sample and restarts the machine.
      st_phase   = PH_READY;
      st_window  = '0;
      st_calm    = '0;
      st_peak_hi = '0;
      st_peak_lo = '0;
      r.phase    = PH_READY;
      return r;
    end
    dx  = s.ax - cf_offset_x;
    dy  = s.ay - cf_offset_y;
    dz  = s.az - cf_offset_z;
    mag = 18'(abs17(dx)) + 18'(abs17(dy)) + 18'(abs17(dz));
    case (st_phase)
      PH_READY: begin
        if (mag > cf_hit_thr) begin
          st_window  = 3'd1;
          st_peak_hi = (dy > 0) ? dy[15:0] : '0;
          st_peak_lo = (dy < 0) ? dy : '0;
          st_phase   = PH_DETECT;
        end
      end
      PH_DETECT: begin
        if (dy > $signed({1'b0, st_peak_hi})) st_peak_hi = dy[15:0];
        if (dy < st_peak_lo) st_peak_lo = dy;
        st_window = st_window + 3'd1;
        if (st_window >= WINDOW_SAMPLES) begin
          r             = classify_strike();
          st_cool_start = s.t;
          st_calm       = '0;
          st_phase      = PH_COOL;
        end
      end
      default: begin
        if (mag < cf_rest_thr) begin
          st_calm = st_calm + 2'd1;
          if (st_calm >= CALM_NEEDED) begin
            st_phase = PH_READY;
            st_calm  = '0;
          end
        end else if (s.t - st_cool_start > COOL_TIMEOUT_MS) begin
          st_phase = PH_READY;
          st_calm  = '0;
        end else begin
          st_calm = '0;
        end
      end
    endcase
    r.phase = st_phase;
    return r;
  endfunction

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      errors++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Everything is sampled at the rising edge. Results are checked first,
  // then register writes update the configuration copy, and finally an
  // accepted sample is run through the predictor. Register writes only
  // happen while no sample is in flight, so this order never matters.
  always @(posedge clk) begin : scoreboard
    hit_result_t   want;
    accel_sample_t smp;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $error("result request arrived with no sample outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("hit", 4'(want.hit), 4'(out_if.hit));
          check_field("zone", 4'(want.zone), 4'(out_if.zone));
          check_field("track", want.track, out_if.track);
          check_field("led_color", 4'(want.led), 4'(out_if.led_color));
          check_field("phase_now", 4'(want.phase), 4'(out_if.phase_now));
          if (want.hit) hits_by_zone[want.zone]++;
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_OFFSET_X:      cf_offset_x = cfg_wdata[15:0];
          REG_OFFSET_Y:      cf_offset_y = cfg_wdata[15:0];
          REG_OFFSET_Z:      cf_offset_z = cfg_wdata[15:0];
          REG_STYLE:         cf_style    = cfg_wdata[1:0];
          REG_SECOND_PLAYER: cf_second   = cfg_wdata[0];
          REG_STRIKE_LEVEL:  cf_hit_thr  = cfg_wdata;
          REG_CALM_LEVEL:    cf_rest_thr = cfg_wdata;
          REG_AXIS_ZONE:     cf_axis     = cfg_wdata[16:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        smp.ax    = in_if.accel_x;
        smp.ay    = in_if.accel_y;
        smp.az    = in_if.accel_z;
        smp.t     = in_if.time_ms;
        smp.rearm = in_if.rearm;
        pending_results.push_back(predict_hit_result(smp));
      end
    end
  end

  // The result side stalls at random; the stall rate changes per phase.
  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= sink_gap_pct);
  end

  // A hung block must not keep the run going forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("impact_detector_direction_classifier_top test failed");
      $finish;
    end
  end

  // Sends one request and returns at the rising edge that accepts it. Valid
  // is left high so that a following request can go out back to back.
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, logic [31:0] t, logic rearm);
    @(negedge clk);
    while ($urandom_range(99) < src_gap_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.accel_x = ax;
    in_if.accel_y = ay;
    in_if.accel_z = az;
    in_if.time_ms = t;
    in_if.rearm   = rearm;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic int sdev(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // Sends a sample whose deviations from the current offsets are given,
  // saturated to the sensor range, dt milliseconds after the previous one.
  task automatic send_deviation(int dx, int dy, int dz, int dt);
    stamp_ms = stamp_ms + 32'(dt);
    samples_sent++;
    send_sample(clamp16(dx + int'(cf_offset_x)), clamp16(dy + int'(cf_offset_y)),
                clamp16(dz + int'(cf_offset_z)), stamp_ms, 1'b0);
  endtask

  // The payload of a rearm request is junk that the block must ignore.
  task automatic send_rearm();
    rearms_sent++;
    send_sample(16'($urandom), 16'($urandom), 16'($urandom), $urandom, 1'b1);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
  endtask

  task automatic apply_setting(logic signed [15:0] ox, logic signed [15:0] oy,
                               logic signed [15:0] oz, logic [1:0] sty, logic sp,
                               logic [17:0] hit_thr, logic [17:0] rest_thr,
                               logic [16:0] axis);
    write_reg(REG_OFFSET_X, {2'b00, ox});
    write_reg(REG_OFFSET_Y, {2'b00, oy});
    write_reg(REG_OFFSET_Z, {2'b00, oz});
    write_reg(REG_STYLE, {16'd0, sty});
    write_reg(REG_SECOND_PLAYER, {17'd0, sp});
    write_reg(REG_STRIKE_LEVEL, hit_thr);
    write_reg(REG_CALM_LEVEL, rest_thr);
    write_reg(REG_AXIS_ZONE, {1'b0, axis});
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Holds the sender off until every expected result has come back, then
  // lets the two-stage pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register defaults straight out of reset: a strike that swings mostly
  // positive on Y is a right hit, and two calm samples end the cooling.
  task automatic test_default_strike();
    send_deviation(7000, 0, 0, 10);
    send_deviation(0, 5000, 0, 10);
    send_deviation(0, -1000, 0, 10);
    send_deviation(0, 4001, 0, 10);
    send_deviation(0, 0, 0, 10);
    send_deviation(0, 200, 0, 10);
    send_deviation(100, 100, 100, 10);
    send_deviation(100, 100, 100, 10);
  endtask

  // Full-scale samples against full-scale offsets give the largest possible
  // deviations and magnitude. An unused style code must act as the swapped
  // layout, so the left hit plays the highest track.
  task automatic test_extreme_samples();
    int k;
    drain_results();
    apply_setting(-16'sd32768, 16'sd32767, -16'sd32768, 2'd3, 1'b1,
                  18'd0, 18'h3FFFF, 17'd0);
    samples_sent++;
    send_sample(16'sd32767, -16'sd32768, 16'sd32767, 32'hFFFF_FFF0, 1'b0);
    for (k = 0; k < 5; k++) begin
      samples_sent++;
      send_sample(-16'sd32768, 16'sd32767, -16'sd32768,
                  (k == 4) ? 32'hFFFF_FFFF : 32'hFFFF_FFF1 + 32'(k), 1'b0);
    end
    send_rearm();
  endtask

  // Equal positive and negative peaks classify as middle. The cooling
  // timeout is measured across the wrap of the millisecond counter: exactly
  // the timeout keeps cooling, one millisecond more returns to ready.
  task automatic test_timeout_wrap();
    drain_results();
    apply_setting(16'sd0, 16'sd0, 16'sd0, STYLE_METAL, 1'b0,
                  STRIKE_LEVEL_RST, CALM_LEVEL_RST, AXIS_ZONE_RST);
    stamp_ms = 32'hFFFF_FF00;
    send_deviation(0, 9000, 0, 0);
    send_deviation(0, -9000, 0, 1);
    repeat (4) send_deviation(0, 0, 0, 1);
    send_deviation(3000, 0, 0, 250);
    send_deviation(3000, 0, 0, 1);
  endtask

  // A rearm in the middle of a window abandons it; a following sample
  // below the threshold leaves the block in ready.
  task automatic test_rearm();
    send_deviation(20000, 0, 0, 5);
    send_deviation(0, 8000, 0, 5);
    send_rearm();
    send_deviation(3000, 1000, 1000, 5);
  endtask

  // One burst of random traffic. Most bursts are complete strikes with
  // random content, followed by a cooling stretch that is calm, loud, or
  // long enough to time out. The rest is noise, rearms and calm samples.
  task automatic run_episode();
    int pick;
    int k;
    int dt;
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_deviation(sdev(32767), sdev(32767), sdev(32767), $urandom_range(40));
      for (k = 0; k < 5; k++) begin
        if ($urandom_range(99) < 4) send_rearm();
        send_deviation(sdev(4000), $urandom_range(1) ? sdev(30000) : sdev(1500),
                       sdev(4000), $urandom_range(40));
      end
      repeat ($urandom_range(4)) begin
        dt = ($urandom_range(9) == 0) ? $urandom_range(400, 200) : $urandom_range(60);
        if ($urandom_range(99) < 60) begin
          send_deviation(sdev(300), sdev(300), sdev(300), dt);
        end else begin
          send_deviation(sdev(8000), sdev(8000), sdev(8000), dt);
        end
      end
    end else if (pick < 85) begin
      // Noise: raw full-range samples, sometimes at a random timestamp.
      if ($urandom_range(3) == 0) begin
        stamp_ms = $urandom;
      end else begin
        stamp_ms = stamp_ms + 32'($urandom_range(100));
      end
      samples_sent++;
      send_sample(16'($urandom), 16'($urandom), 16'($urandom), stamp_ms, 1'b0);
    end else if (pick < 90) begin
      send_rearm();
    end else begin
      repeat ($urandom_range(3, 1)) send_deviation(sdev(300), sdev(300), sdev(300),
                                                   $urandom_range(30));
    end
  endtask

  // Six register settings, the extremes among them, each with its own burst
  // of random traffic. The first two run with a nearly steady sender and a
  // slow receiver, the next two the other way round, the last two with no
  // idling on either side.
  task automatic test_random_settings();
    int p;
    int goal;
    for (p = 0; p < 6; p++) begin
      drain_results();
      case (p)
        0: apply_setting(16'sd0, 16'sd0, 16'sd0, STYLE_ROCK, 1'b0,
                         18'd6000, 18'd1500, 17'd4000);
        1: apply_setting(16'(sdev(2000)), 16'(sdev(2000)), 16'(sdev(2000)),
                         STYLE_METAL, 1'b0, 18'd3000, 18'd2500, 17'd2000);
        2: apply_setting(-16'sd32768, 16'sd32767, -16'sd32768, STYLE_METAL, 1'b1,
                         18'd0, 18'h3FFFF, 17'd0);
        3: apply_setting(16'(sdev(2000)), 16'(sdev(2000)), 16'(sdev(2000)),
                         2'd2, 1'b0, 18'd8000, 18'd1000, 17'd8000);
        4: apply_setting(16'sd32767, -16'sd32768, 16'sd32767, 2'd3, 1'b1,
                         18'h3FFFF, 18'd0, 17'h1FFFF);
        default: apply_setting(16'(sdev(2000)), 16'(sdev(2000)), 16'(sdev(2000)),
                               2'd2, 1'b1, 18'd5000, 18'd2000, 17'd3000);
      endcase
      if (p < 2) begin
        src_gap_pct  = 9;
        sink_gap_pct = 67;
      end else if (p < 4) begin
        src_gap_pct  = 67;
        sink_gap_pct = 9;
      end else begin
        src_gap_pct  = 0;
        sink_gap_pct = 0;
      end
      goal = samples_sent + 140;
      while (samples_sent < goal) run_episode();
    end
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.accel_x = '0;
    in_if.accel_y = '0;
    in_if.accel_z = '0;
    in_if.time_ms = '0;
    in_if.rearm   = 1'b0;
    out_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    src_gap_pct   = 9;
    sink_gap_pct  = 67;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_strike();
    test_extreme_samples();
    test_timeout_wrap();
    test_rearm();
    test_random_settings();
    drain_results();

    $display("Checked %0d results for %0d samples and %0d rearm requests.",
             results_seen, samples_sent, rearms_sent);
    $display("Hits seen: %0d middle, %0d left, %0d right, across nine register settings.",
             hits_by_zone[ZONE_MIDDLE], hits_by_zone[ZONE_LEFT], hits_by_zone[ZONE_RIGHT]);
    if (errors == 0) begin
      $display("impact_detector_direction_classifier_top test passed");
    end else begin
      $display("impact_detector_direction_classifier_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/idc_pkg.sv
src/idc_if.sv
src/idc_cfg.sv
src/idc_front.sv
src/idc_core.sv
src/impact_detector_direction_classifier_top.sv
verif/testbench.sv
